@@ sv/upsc_pkg.sv @@
// shared types and constants of the pixel replication upscaler
package upsc_pkg;

   localparam int PIXEL_W     = 24;
   localparam int SCALE_W     = 7;
   localparam int ROW_W       = 13;
   localparam int PAD_W       = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   // largest replication factor
   localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

   // request opcodes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH    = 1'd1;

   // side information of one result, from the control unit to the output stage
   typedef struct packed {
      logic             result;
      logic             row_end;
      logic [PAD_W-1:0] pad_bytes;
      logic             copies_done;
      logic             overrun;
   } rsp_info_type;

endpackage

@@ sv/upsc_if.sv @@
// request and response channel interfaces of the upscaler
interface upsc_req_if;
   import upsc_pkg::*;
   logic               valid;
   logic               ready;
   logic               op;
   logic [PIXEL_W-1:0] pixel_in;

   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface upsc_rsp_if;
   import upsc_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               row_end;
   logic [PAD_W-1:0]   pad_bytes;
   logic               copies_done;
   logic               overrun;

   modport source (output valid, output pixel_out, output row_end, output pad_bytes,
                   output copies_done, output overrun, input ready);
   modport sink   (input valid, input pixel_out, input row_end, input pad_bytes,
                   input copies_done, input overrun, output ready);
endinterface

@@ sv/upsc_line_mem.sv @@
// single line store: one write port, one registered read port
module upsc_line_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [upsc_pkg::PIXEL_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [upsc_pkg::PIXEL_W-1:0]  rd_data
);
   import upsc_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/upsc_ctrl.sv @@
// fill and emission counters, store addressing and result flags
module upsc_ctrl #(
   parameter int MAX_WIDTH = 4096,
   parameter int AW        = 12,
   parameter int CW        = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          op,
   input  logic [upsc_pkg::PIXEL_W-1:0]  pixel_in,
   input  logic [upsc_pkg::SCALE_W-1:0]  scale_cfg,
   input  logic [upsc_pkg::ROW_W-1:0]    width_cfg,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [upsc_pkg::PIXEL_W-1:0]  wr_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output upsc_pkg::rsp_info_type        info
);
   import upsc_pkg::*;

   localparam int WW = (CW > ROW_W) ? CW : ROW_W;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

   logic [CW-1:0]      fill_ff, fill_in;
   logic               loaded_ff, loaded_in;
   logic [AW-1:0]      col_ff, col_in;
   logic [SCALE_W-1:0] hrep_ff, hrep_in;
   logic [SCALE_W-1:0] vcopy_ff, vcopy_in;
   logic               overrun_ff, overrun_in;

   logic [SCALE_W-1:0] eff_s;
   logic [WW-1:0]      width_ext;
   logic [WW-1:0]      eff_w_ext;
   logic [CW-1:0]      eff_w;
   logic               fill_full;
   logic [CW:0]        fill_inc;
   logic               loaded_now;
   logic [AW-1:0]      cur_col;
   logic [SCALE_W-1:0] cur_h;
   logic [SCALE_W-1:0] cur_v;
   logic               h_last;
   logic               c_last;
   logic               v_last;
   logic [PAD_W-1:0]   pad_prod;

   // effective scale and width, out-of-range values clamped
   assign width_ext = WW'(width_cfg);
   always_comb begin
      priority if (scale_cfg == '0) begin
         eff_s = SCALE_W'(1);
      end else if (scale_cfg > SCALE_MAX) begin
         eff_s = SCALE_MAX;
      end else begin
         eff_s = scale_cfg;
      end
      priority if (width_ext == '0) begin
         eff_w_ext = WW'(1);
      end else if (width_ext > MAX_W) begin
         eff_w_ext = MAX_W;
      end else begin
         eff_w_ext = width_ext;
      end
   end
   assign eff_w = CW'(eff_w_ext);

   // row status and the counters as seen by a pull
   assign fill_full  = (fill_ff >= eff_w);
   assign fill_inc   = (CW+1)'(fill_ff) + (CW+1)'(1);
   assign loaded_now = loaded_ff || fill_full;
   assign cur_col    = loaded_ff ? col_ff   : '0;
   assign cur_h      = loaded_ff ? hrep_ff  : '0;
   assign cur_v      = loaded_ff ? vcopy_ff : '0;
   assign h_last     = ((SCALE_W+1)'(cur_h) + (SCALE_W+1)'(1)) >= (SCALE_W+1)'(eff_s);
   assign v_last     = ((SCALE_W+1)'(cur_v) + (SCALE_W+1)'(1)) >= (SCALE_W+1)'(eff_s);
   assign c_last     = ((CW+1)'(cur_col) + (CW+1)'(1)) >= (CW+1)'(eff_w);

   // pad count: 3*w*s bytes, so (4 - 3ws mod 4) mod 4 equals ws mod 4
   assign pad_prod = PAD_W'(eff_w) * PAD_W'(eff_s);

   // store ports
   assign wr_addr = AW'(fill_ff);
   assign wr_data = pixel_in;
   assign rd_addr = cur_col;

   // next state
   always_comb begin
      fill_in    = fill_ff;
      loaded_in  = loaded_ff;
      col_in     = col_ff;
      hrep_in    = hrep_ff;
      vcopy_in   = vcopy_ff;
      overrun_in = overrun_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      info       = '0;
      info.overrun = overrun_ff;
      if (accept && (op == OP_PUSH)) begin
         if (loaded_ff || fill_full) begin
            overrun_in = 1'b1;
         end else begin
            wr_en   = 1'b1;
            fill_in = CW'(fill_inc);
            if (fill_inc >= (CW+1)'(eff_w)) begin
               loaded_in = 1'b1;
               col_in    = '0;
               hrep_in   = '0;
               vcopy_in  = '0;
            end
         end
      end else if (accept && loaded_now) begin
         rd_en       = 1'b1;
         info.result = 1'b1;
         loaded_in   = 1'b1;
         col_in      = cur_col;
         hrep_in     = cur_h;
         vcopy_in    = cur_v;
         if (h_last) begin
            hrep_in = '0;
            if (c_last) begin
               info.row_end   = 1'b1;
               info.pad_bytes = pad_prod;
               col_in         = '0;
               if (v_last) begin
                  info.copies_done = 1'b1;
                  vcopy_in         = '0;
                  loaded_in        = 1'b0;
                  fill_in          = '0;
               end else begin
                  vcopy_in = cur_v + SCALE_W'(1);
               end
            end else begin
               col_in = cur_col + AW'(1);
            end
         end else begin
            hrep_in = cur_h + SCALE_W'(1);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         loaded_ff  <= 1'b0;
         col_ff     <= '0;
         hrep_ff    <= '0;
         vcopy_ff   <= '0;
         overrun_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         loaded_ff  <= loaded_in;
         col_ff     <= col_in;
         hrep_ff    <= hrep_in;
         vcopy_ff   <= vcopy_in;
         overrun_ff <= overrun_in;
      end
   end

endmodule

@@ sv/pixel_replication_upscaler.sv @@
// top level of the nearest-neighbor integer pixel replication upscaler
//
// channel  direction  content
// req_if   in         op (0 push, 1 pull), pixel_in
// rsp_if   out        pixel_out, row_end, pad_bytes, copies_done, overrun
// csr_*    in         write enable, register index, write data
//
// a push writes the line store at its accepting edge; a pull that yields a pixel reads
// the store at its accepting edge and moves to the output register once that register is free
// requests are taken every cycle while the output register drains; a stalled
// response holds one pull in the store read stage and blocks further requests
// reset is synchronous and needs no clearing pass over the line store
module pixel_replication_upscaler #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   upsc_req_if.sink                         req_if,
   upsc_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [upsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [upsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import upsc_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [SCALE_W-1:0] scale_ff;
   logic [ROW_W-1:0]   width_ff;
   logic               busy_ff;
   rsp_info_type       info_ff;
   rsp_info_type       ctrl_info;
   logic               out_valid_ff;
   logic [PIXEL_W-1:0] pixel_ff;
   logic               row_end_ff;
   logic [PAD_W-1:0]   pad_ff;
   logic               done_ff;
   logic               overrun_ff;

   logic               accept;
   logic               load;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [PIXEL_W-1:0] rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(1);
         width_ff <= ROW_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR: scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_ROW_WIDTH:    width_ff <= csr_wdata[ROW_W-1:0];
            default:          ;
         endcase
      end
   end

   // handshake: a pending pull moves to the output register when it is free
   assign load          = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !busy_ff || load;
   assign accept        = req_if.valid && req_if.ready;

   upsc_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_if.op),
      .pixel_in  (req_if.pixel_in),
      .scale_cfg (scale_ff),
      .width_cfg (width_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .info      (ctrl_info)
   );

   upsc_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= ctrl_info.result;
      end else if (load) begin
         busy_ff <= 1'b0;
      end
   end

   // side information travels with the store read
   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= ctrl_info;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff   <= rd_data;
         row_end_ff <= info_ff.row_end;
         pad_ff     <= info_ff.pad_bytes;
         done_ff    <= info_ff.copies_done;
         overrun_ff <= info_ff.overrun;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.pixel_out   = pixel_ff;
   assign rsp_if.row_end     = row_end_ff;
   assign rsp_if.pad_bytes   = pad_ff;
   assign rsp_if.copies_done = done_ff;
   assign rsp_if.overrun     = overrun_ff;

endmodule

@@ sv/upsc_checker.sv @@
// port-level assertions for the upscaler, bound to the top level
module upsc_checker (
   input logic        clock,
   input logic        reset,
   upsc_req_if.sink   req_if,
   upsc_rsp_if.source rsp_if
);
   import upsc_pkg::*;

   // a stalled response keeps its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.pixel_out))
      else $error("response changed while stalled");

   // padding and end of copies only on the last pixel of a row
   a_row_end_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.row_end |-> (rsp_if.pad_bytes == '0) && !rsp_if.copies_done)
      else $error("pad or copies_done outside row end");

   // overrun never clears without reset
   a_overrun_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.overrun |=> !(rsp_if.valid && !rsp_if.overrun))
      else $error("overrun flag cleared");

   // a fresh response follows an accepted request through the store read stage and the output register
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(req_if.valid && req_if.ready, 2))
      else $error("response without matching request");

endmodule

bind pixel_replication_upscaler upsc_checker u_upsc_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

@@ verif/pixel_replication_upscaler_tb.sv @@
// self-checking testbench for the pixel replication upscaler: directed and random rows
module pixel_replication_upscaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import upsc_pkg::*;

   localparam int MAX_WIDTH    = 4096;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 32;
   localparam int RANDOM_PHASES = 16;

   typedef enum {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      op_type             op;
      logic [PIXEL_W-1:0] pixel;
   } pixel_request_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic [PAD_W-1:0]   pad_bytes;
      logic               copies_done;
      logic               overrun;
   } out_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   upsc_req_if req_if();
   upsc_rsp_if rsp_if();

   pixel_replication_upscaler #(.MAX_WIDTH(MAX_WIDTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // requests waiting to be offered and pixels waiting to come out
   pixel_request_type pending_requests[$];
   out_pixel_type     expected_pixels[$];
   int unsigned       mismatch_count = 0;
   pace_type          pace = PACE_FULL;
   bit                req_fire = 1'b0;
   bit                hold_req = 1'b0;
   int unsigned       hold_left = 0;

   // shadow of the upscaler state and its registers
   logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [12:0]        fill_cnt = '0;
   bit                 row_loaded = 1'b0;
   logic [11:0]        read_col = '0;
   logic [SCALE_W-1:0] h_repeat = '0;
   logic [SCALE_W-1:0] v_copy = '0;
   bit                 sticky_overrun = 1'b0;
   logic [SCALE_W-1:0] scale_reg = 7'd1;
   logic [ROW_W-1:0]   width_reg = 13'd1;

   initial begin
      req_if.valid    = 1'b0;
      req_if.op       = OP_PUSH;
      req_if.pixel_in = '0;
      rsp_if.ready    = 1'b0;
   end

   always #1 clock = ~clock;

   // zero acts as one, values over the top act as the top
   function automatic int unsigned clamp_limit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit pause_now(bit for_sender);
      int unsigned roll;
      roll = $urandom_range(99);
      if (pace == PACE_BOTH) return roll < 8;
      if (for_sender) return pace == PACE_SENDER_IDLE && roll < 81;
      return pace == PACE_RECEIVER_STALL && roll < 81;
   endfunction

   function automatic void begin_emission();
      row_loaded = 1'b1;
      read_col   = '0;
      h_repeat   = '0;
      v_copy     = '0;
   endfunction

   // one accepted request: update the shadow state and queue the pixel it yields
   function automatic void replicate_step(op_type op, logic [PIXEL_W-1:0] pix);
      int unsigned   w;
      int unsigned   s;
      int unsigned   row_bytes;
      out_pixel_type r;
      w = clamp_limit(width_reg, MAX_WIDTH);
      s = clamp_limit(scale_reg, SCALE_MAX);
      if (op == OP_PUSH) begin
         if (row_loaded || fill_cnt >= w) begin
            sticky_overrun = 1'b1;
         end else begin
            line_mem[fill_cnt] = pix;
            fill_cnt++;
            if (fill_cnt >= w) begin_emission();
         end
         return;
      end
      // pull with nothing loaded yields nothing, unless the width was lowered
      if (!row_loaded) begin
         if (fill_cnt >= w) begin_emission();
         else return;
      end
      r = '0;
      r.pixel = line_mem[read_col];
      if (h_repeat + 1 >= s) begin
         h_repeat = '0;
         if (read_col + 1 >= w) begin
            row_bytes   = 3 * w * s;
            r.row_end   = 1'b1;
            r.pad_bytes = PAD_W'((4 - row_bytes % 4) % 4);
            read_col    = '0;
            if (v_copy + 1 >= s) begin
               r.copies_done = 1'b1;
               v_copy        = '0;
               row_loaded    = 1'b0;
               fill_cnt      = '0;
            end else begin
               v_copy++;
            end
         end else begin
            read_col++;
         end
      end else begin
         h_repeat++;
      end
      r.overrun = sticky_overrun;
      expected_pixels.push_back(r);
   endfunction

   // request driver: a new request is offered only once the previous one is taken
   always @(negedge clock) begin : drive_requests
      pixel_request_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_requests.size() != 0 && !pause_now(1'b1)) begin
            item = pending_requests.pop_front();
            req_if.valid    <= 1'b1;
            req_if.op       <= item.op;
            req_if.pixel_in <= item.pixel;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left <= LONG_HOLD;
         hold_req = 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response ready
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= hold_left == 0 && !pause_now(1'b0);
   end

   // monitor: check results, track register writes, predict from accepted requests
   always @(posedge clock) begin : monitor
      out_pixel_type got;
      out_pixel_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got.pixel       = rsp_if.pixel_out;
            got.row_end     = rsp_if.row_end;
            got.pad_bytes   = rsp_if.pad_bytes;
            got.copies_done = rsp_if.copies_done;
            got.overrun     = rsp_if.overrun;
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected pixel %h row_end %b pad %0d done %b ovr %b",
                           $realtime, got.pixel, got.row_end, got.pad_bytes,
                           got.copies_done, got.overrun);
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
                   got.pad_bytes !== want.pad_bytes ||
                   got.copies_done !== want.copies_done ||
                   got.overrun !== want.overrun) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"%0t: pixel %h/%h row_end %b/%b pad %0d/%0d ",
                               "done %b/%b ovr %b/%b (expected/actual)"},
                              $realtime, want.pixel, got.pixel, want.row_end,
                              got.row_end, want.pad_bytes, got.pad_bytes,
                              want.copies_done, got.copies_done, want.overrun,
                              got.overrun);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_SCALE_FACTOR) scale_reg = csr_wdata[SCALE_W-1:0];
            else if (csr_index == CSR_ROW_WIDTH) width_reg = csr_wdata[ROW_W-1:0];
         end
         if (req_fire) replicate_step(op_type'(req_if.op), req_if.pixel_in);
      end
   end

   function automatic void add_push(logic [PIXEL_W-1:0] pix);
      pixel_request_type item;
      item.op    = OP_PUSH;
      item.pixel = pix;
      pending_requests.push_back(item);
   endfunction

   // pulls carry random pixel bits, which the block ignores
   function automatic void add_pulls(int unsigned n);
      pixel_request_type item;
      repeat (n) begin
         item.op    = OP_PULL;
         item.pixel = PIXEL_W'($urandom);
         pending_requests.push_back(item);
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      return PIXEL_W'($urandom);
   endfunction

   // wait until every request is taken and every pixel is back, then let the block settle
   task automatic drain();
      while (pending_requests.size() != 0 || req_if.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // whole rows at one random setting, with dropped pushes and empty pulls mixed in
   task automatic random_phase(pace_type p, bit long_hold);
      int unsigned s_val;
      int unsigned w_val;
      int unsigned s_eff;
      int unsigned w_eff;
      int unsigned made;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) s_val = 0;
      else if (roll < 10) s_val = $urandom_range(5, 6);
      else s_val = $urandom_range(1, 4);
      roll = $urandom_range(99);
      if (roll < 5) w_val = 0;
      else if (roll < 12) w_val = $urandom_range(13, 40);
      else w_val = $urandom_range(1, 8);
      if (w_val > 8 && s_val > 2) s_val = 2;
      s_eff = clamp_limit(s_val, SCALE_MAX);
      w_eff = clamp_limit(w_val, MAX_WIDTH);
      write_reg(CSR_SCALE_FACTOR, {6'($urandom_range(63)), 7'(s_val)});
      write_reg(CSR_ROW_WIDTH, 13'(w_val));
      pace = p;
      if (long_hold) hold_req = 1'b1;
      made = 0;
      while (made < PHASE_ITEMS) begin
         for (int k = 0; k < w_eff; k++) begin
            if ($urandom_range(99) < 10) add_pulls(1);
            add_push(random_pixel());
            made++;
         end
         for (int k = 0; k < w_eff * s_eff * s_eff; k++) begin
            if ($urandom_range(99) < 8) add_push(random_pixel());
            add_pulls(1);
            made++;
         end
      end
      drain();
   endtask

   // stimulus
   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: empty pull, single-pixel rows with black and white
      add_pulls(1);
      add_push(24'h000000);
      add_pulls(1);
      add_push(24'hFFFFFF);
      add_pulls(1);
      drain();

      // scale two on a two-pixel row, a push during emission is dropped
      write_reg(CSR_SCALE_FACTOR, 13'd2);
      write_reg(CSR_ROW_WIDTH, 13'd2);
      add_push(24'hABCDEF);
      add_push(24'h123456);
      add_pulls(3);
      add_push(24'h555555);
      add_pulls(5);
      drain();

      // zero scale, width lowered mid-fill: extra push dropped, row loads on pull
      write_reg(CSR_ROW_WIDTH, 13'd5);
      write_reg(CSR_SCALE_FACTOR, 13'd0);
      add_push(24'h800001);
      add_push(24'h7FFFFE);
      add_push(24'hC3C3C3);
      drain();
      write_reg(CSR_ROW_WIDTH, 13'd2);
      add_push(24'h010203);
      add_pulls(2);
      drain();

      // zero width, scale over the top then at the top, lowered to one mid-row
      write_reg(CSR_ROW_WIDTH, 13'd0);
      write_reg(CSR_SCALE_FACTOR, 13'd127);
      add_push(24'h3C5A96);
      add_pulls(2);
      drain();
      write_reg(CSR_SCALE_FACTOR, 13'd100);
      add_pulls(2);
      drain();
      write_reg(CSR_SCALE_FACTOR, 13'd1);
      add_pulls(1);
      drain();

      // random rows, cycling through the pacing modes
      for (int i = 0; i < RANDOM_PHASES; i++)
         random_phase(pace_type'(i % 4), i == 4);

      // width over the top acts as the full line store: a short fill loads no row
      pace = PACE_FULL;
      write_reg(CSR_SCALE_FACTOR, 13'd1);
      write_reg(CSR_ROW_WIDTH, 13'd8191);
      repeat (3) add_push(random_pixel());
      add_pulls(1);
      drain();
      write_reg(CSR_ROW_WIDTH, 13'd3);
      add_pulls(3);
      drain();

      mismatch_count += expected_pixels.size();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
sv/upsc_pkg.sv
sv/upsc_if.sv
sv/upsc_line_mem.sv
sv/upsc_ctrl.sv
sv/pixel_replication_upscaler.sv
sv/upsc_checker.sv
verif/pixel_replication_upscaler_tb.sv
